// ===== hdl/esp_pkg.sv =====
package esp_pkg;

  // Field widths fixed by the interface.
  localparam int WEIGHT_W = 17;
  localparam int COEFF_W  = 64;
  localparam int IDX_W    = 5;
  localparam int BLEN_W   = 13;
  localparam int CFG_IDX_W = 2;

  // Default sizes handed to the top level.
  localparam int DEFAULT_MAX_DEGREE = 31;
  localparam int DEFAULT_MAX_ITEMS  = 4096;

  // 1.0 in Q1.16 and Q48.16.
  localparam logic [WEIGHT_W-1:0] ONE_Q16 = 17'h10000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN    = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [IDX_W-1:0]  DEGREE_LIMIT_RST = 5'd31;
  localparam logic [BLEN_W-1:0] BLOCK_LEN_RST    = 13'd64;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_DRAIN
  } esp_state_t;

  // Control word broadcast to every cell of the chain.
  typedef struct packed {
    logic                mul_en;
    logic                add_en;
    logic                clear;
    logic                snap_load;
    logic                snap_shift;
    logic [WEIGHT_W-1:0] weight;
    logic [IDX_W-1:0]    dlim;
  } cell_ctrl_t;

endpackage

// ===== hdl/esp_cell.sv =====
module esp_cell #(
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  esp_pkg::cell_ctrl_t         ctrl,
  input  logic [esp_pkg::COEFF_W-1:0] left_coeff,
  input  logic [esp_pkg::COEFF_W-1:0] right_snap,
  input  logic                        right_snap_sat,
  output logic [esp_pkg::COEFF_W-1:0] coeff,
  output logic [esp_pkg::COEFF_W-1:0] snap,
  output logic                        snap_sat
);
  import esp_pkg::*;

  localparam logic [COEFF_W-1:0] RESET_VAL =
    (IDX == 0) ? COEFF_W'(ONE_Q16) : '0;
  localparam int PROD_W = COEFF_W + WEIGHT_W;

  logic [COEFF_W-1:0] coeff_r;
  logic               sat_r;
  logic [COEFF_W-1:0] prod_r;
  logic               povf_r;
  logic [COEFF_W-1:0] snap_r;
  logic               snap_sat_r;

  logic [PROD_W-1:0]  full_prod;
  logic [COEFF_W:0]   sum;
  logic               active;
  logic               upd_sat;
  logic [COEFF_W-1:0] coeff_upd;
  logic               sat_upd;

  // This degree takes part only between 1 and the degree limit.
  assign active = (IDX >= 1) && (IDX <= int'(ctrl.dlim));

  // Scaled product of the lower neighbor with the weight, truncated.
  assign full_prod = PROD_W'(left_coeff) * PROD_W'(ctrl.weight);

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= full_prod[16 +: COEFF_W];
      povf_r <= |full_prod[PROD_W-1:16+COEFF_W];
    end
  end

  // Accumulate with saturation to all ones.
  assign sum     = {1'b0, coeff_r} + {1'b0, prod_r};
  assign upd_sat = povf_r | sum[COEFF_W];

  always_comb begin
    coeff_upd = coeff_r;
    sat_upd   = sat_r;
    if (ctrl.add_en && active) begin
      coeff_upd = upd_sat ? '1 : sum[COEFF_W-1:0];
      sat_upd   = sat_r | upd_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r <= RESET_VAL;
      sat_r   <= 1'b0;
    end else if (ctrl.clear) begin
      coeff_r <= RESET_VAL;
      sat_r   <= 1'b0;
    end else begin
      coeff_r <= coeff_upd;
      sat_r   <= sat_upd;
    end
  end

  // Snapshot copy, drained toward degree zero one word at a time.
  always_ff @(posedge clk) begin
    if (ctrl.snap_load) begin
      snap_r     <= coeff_upd;
      snap_sat_r <= sat_upd;
    end else if (ctrl.snap_shift) begin
      snap_r     <= right_snap;
      snap_sat_r <= right_snap_sat;
    end
  end

  assign coeff    = coeff_r;
  assign snap     = snap_r;
  assign snap_sat = snap_sat_r;

endmodule

// ===== hdl/elementary_symmetric_poly_accumulator_core.sv =====
// Channel  Direction  Handshake            Word
// in_      input      in_valid / in_stall  in_weight, in_last_item
// out_     output     out_valid/out_stall  coeff_index, value, flags, boundary
// cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_wdata
//
// An item is accepted, then multiplied in every cell, then accumulated in the
// cells of degree 1 to the degree limit. A checkpoint then drains degree_limit+1
// words from the snapshot chain, one per cycle while out_stall is low; no item is
// taken meanwhile. Reset is synchronous; no clearing pass. cfg_ready is always high.
module elementary_symmetric_poly_accumulator_core #(
  parameter int MAX_DEGREE = esp_pkg::DEFAULT_MAX_DEGREE,
  parameter int MAX_ITEMS  = esp_pkg::DEFAULT_MAX_ITEMS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [esp_pkg::WEIGHT_W-1:0]  in_weight,
  input  logic                          in_last_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [esp_pkg::IDX_W-1:0]     out_coeff_index,
  output logic [esp_pkg::COEFF_W-1:0]   out_coeff_value,
  output logic                          out_saturated,
  output logic [esp_pkg::BLEN_W-1:0]    out_boundary_number,
  output logic                          out_is_final,
  output logic                          out_end_of_run,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [esp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [esp_pkg::BLEN_W-1:0]    cfg_wdata
);
  import esp_pkg::*;

  localparam int CELLS = MAX_DEGREE + 1;
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam logic [IDX_W:0]  MAXD  = (IDX_W + 1)'(MAX_DEGREE > 31 ? 31 : MAX_DEGREE);
  localparam logic [CNT_W-1:0] MAXI = CNT_W'(MAX_ITEMS);

  esp_state_t state_r, state_nxt;

  logic [IDX_W-1:0]    deg_cfg_r;
  logic [BLEN_W-1:0]   blen_cfg_r;
  logic [WEIGHT_W-1:0] weight_r;
  logic                last_r;
  logic [IDX_W-1:0]    dlim_r;
  logic [CNT_W-1:0]    blen_r;
  logic [CNT_W-1:0]    pos_r, pos_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [BLEN_W-1:0]   boundary_r, boundary_nxt;
  logic                final_r, final_nxt;

  logic                in_acc;
  logic                out_acc;
  logic                take;
  logic [CNT_W-1:0]    pos_inc;
  logic [IDX_W-1:0]    dlim_in;
  logic [CNT_W-1:0]    blen_in;
  logic [WEIGHT_W-1:0] weight_in;
  cell_ctrl_t          ctrl;

  logic [COEFF_W-1:0]  cell_coeff [CELLS];
  logic [COEFF_W-1:0]  cell_snap  [CELLS];
  logic                cell_ssat  [CELLS];

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_cfg_r  <= DEGREE_LIMIT_RST;
      blen_cfg_r <= BLOCK_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEGREE_LIMIT: deg_cfg_r  <= cfg_wdata[IDX_W-1:0];
        CFG_BLOCK_LEN:    blen_cfg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp weight, degree limit and block length as the item enters.
  assign weight_in = (in_weight > ONE_Q16) ? ONE_Q16 : in_weight;
  assign dlim_in   = ({1'b0, deg_cfg_r} > MAXD) ? MAXD[IDX_W-1:0] : deg_cfg_r;

  always_comb begin
    if (blen_cfg_r == '0) begin
      blen_in = CNT_W'(1);
    end else if (32'(blen_cfg_r) > MAX_ITEMS) begin
      blen_in = MAXI;
    end else begin
      blen_in = CNT_W'(blen_cfg_r);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      weight_r <= weight_in;
      last_r   <= in_last_item;
      dlim_r   <= dlim_in;
      blen_r   <= blen_in;
    end
  end

  // Checkpoint decision at the accumulate step.
  assign pos_inc = pos_r + CNT_W'(1);
  assign take    = (state_r == ST_ADD) && ((pos_inc >= blen_r) || last_r);

  always_comb begin
    pos_nxt      = pos_r;
    cnt_nxt      = cnt_r;
    boundary_nxt = boundary_r;
    final_nxt    = final_r;
    if (state_r == ST_ADD) begin
      pos_nxt = take ? '0 : pos_inc;
      if (take) begin
        cnt_nxt      = (cnt_r < MAXI) ? cnt_r + CNT_W'(1) : cnt_r;
        boundary_nxt = BLEN_W'(cnt_nxt);
        final_nxt    = last_r;
      end
      if (last_r) begin
        pos_nxt = '0;
        cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      cnt_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    boundary_r <= boundary_nxt;
    final_r    <= final_nxt;
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Next state and cell controls.
  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    in_stall        = 1'b1;
    out_valid       = 1'b0;
    ctrl.mul_en     = 1'b0;
    ctrl.add_en     = 1'b0;
    ctrl.clear      = 1'b0;
    ctrl.snap_load  = 1'b0;
    ctrl.snap_shift = 1'b0;
    ctrl.weight     = weight_r;
    ctrl.dlim       = dlim_r;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        ctrl.mul_en = 1'b1;
        state_nxt   = ST_ADD;
      end
      ST_ADD: begin
        ctrl.add_en    = 1'b1;
        ctrl.clear     = last_r;
        ctrl.snap_load = take;
        idx_nxt        = '0;
        state_nxt      = take ? ST_DRAIN : ST_IDLE;
      end
      ST_DRAIN: begin
        out_valid       = 1'b1;
        ctrl.snap_shift = !out_stall;
        if (!out_stall) begin
          idx_nxt = idx_r + IDX_W'(1);
          if (idx_r == dlim_r) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // The chain of coefficient cells.
  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    logic [COEFF_W-1:0] left_c;
    logic [COEFF_W-1:0] right_s;
    logic               right_ss;
    if (k == 0) begin : g_first
      assign left_c = '0;
    end else begin : g_mid
      assign left_c = cell_coeff[k-1];
    end
    if (k == CELLS - 1) begin : g_last
      assign right_s  = '0;
      assign right_ss = 1'b0;
    end else begin : g_inner
      assign right_s  = cell_snap[k+1];
      assign right_ss = cell_ssat[k+1];
    end
    esp_cell #(
      .IDX(k)
    ) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .ctrl           (ctrl),
      .left_coeff     (left_c),
      .right_snap     (right_s),
      .right_snap_sat (right_ss),
      .coeff          (cell_coeff[k]),
      .snap           (cell_snap[k]),
      .snap_sat       (cell_ssat[k])
    );
  end

  // Output word comes from the head of the snapshot chain.
  assign out_coeff_index     = idx_r;
  assign out_coeff_value     = cell_snap[0];
  assign out_saturated       = cell_ssat[0];
  assign out_boundary_number = boundary_r;
  assign out_is_final        = final_r;
  assign out_end_of_run      = (idx_r == dlim_r);

  // The drain never runs past the degree limit.
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (idx_r <= dlim_r))
    else $error("output index beyond degree limit");

  // The last word of a run ends the drain.
  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_end_of_run |=> !out_valid)
    else $error("output still valid after end of run");

  // No item is taken while a snapshot drains.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken during drain");

  // The final item leaves the first degree and the block position cleared.
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADD) && last_r |=> (cell_coeff[1] == '0) && (pos_r == '0))
    else $error("sequence not cleared after last item");

  // Degree zero always holds 1.0.
  a_e0_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (cell_coeff[0] == COEFF_W'(ONE_Q16)))
    else $error("degree zero coefficient changed");

endmodule
